>>> sv/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg - serial check digit decoder package
// Shared widths, codes, record snapshot and result types, region decode.
// ----------------------------------------------------------------------------
package scd_pkg;

    // Size of the fixed serial field in bytes (8 to 32)
    localparam int FIELD_BYTES = 15;

    localparam int POS_W  = $clog2(FIELD_BYTES + 1);
    localparam int CNT_W  = $clog2(FIELD_BYTES + 1);
    localparam int ODD_MAX  = 9 * ((FIELD_BYTES + 1) / 2);
    localparam int EVEN_MAX = 9 * (FIELD_BYTES / 2);
    localparam int ODD_W  = $clog2(ODD_MAX + 1);
    localparam int EVEN_W = $clog2(EVEN_MAX + 1);
    localparam int WSUM_MAX = ODD_MAX + 3 * EVEN_MAX;
    localparam int WSUM_W = $clog2(WSUM_MAX + 1);

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 1029
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int PROD_W      = WSUM_W + 8;

    // Output field widths
    localparam int LEN_W    = 4;
    localparam int DIGIT_W  = 4;
    localparam int REGION_W = 4;
    localparam int SUB_W    = 3;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVKIT     = 2'd0;
    localparam logic [1:0] CFG_MODEL      = 2'd1;
    localparam logic [1:0] CFG_OLD_FAMILY = 2'd2;

    // Console model codes
    localparam logic [7:0] MODEL_OLD    = 8'd0;
    localparam logic [7:0] MODEL_OLD_XL = 8'd1;
    localparam logic [7:0] MODEL_NEW    = 8'd2;
    localparam logic [7:0] MODEL_UNKNOWN = 8'd255;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Sub-model codes
    localparam logic [SUB_W-1:0] SUB_UNKNOWN = 3'd0;
    localparam logic [SUB_W-1:0] SUB_PARTNER = 3'd1;
    localparam logic [SUB_W-1:0] SUB_CTR_BOX = 3'd2;
    localparam logic [SUB_W-1:0] SUB_SPR_BOX = 3'd3;
    localparam logic [SUB_W-1:0] SUB_SNK_BOX = 3'd4;
    localparam logic [SUB_W-1:0] SUB_PANDA   = 3'd5;
    localparam logic [SUB_W-1:0] SUB_PRESS   = 3'd6;
    localparam logic [SUB_W-1:0] SUB_RETAIL  = 3'd7;

    // Region codes
    localparam logic [REGION_W-1:0] REG_UNKNOWN = 4'd0;
    localparam logic [REGION_W-1:0] REG_JP      = 4'd1;
    localparam logic [REGION_W-1:0] REG_AMER    = 4'd2;
    localparam logic [REGION_W-1:0] REG_EU      = 4'd3;
    localparam logic [REGION_W-1:0] REG_CN      = 4'd4;
    localparam logic [REGION_W-1:0] REG_KR      = 4'd5;
    localparam logic [REGION_W-1:0] REG_TW      = 4'd6;
    localparam logic [REGION_W-1:0] REG_UK      = 4'd7;
    localparam logic [REGION_W-1:0] REG_MIDEAST = 4'd8;
    localparam logic [REGION_W-1:0] REG_AU      = 4'd9;
    localparam logic [REGION_W-1:0] REG_BR      = 4'd10;

    typedef struct packed {
        logic       devkit_mode;
        logic [7:0] console_model;
        logic       old_family;
    } t_cfg;

    // Record totals handed from the scanner to the result stage
    typedef struct packed {
        logic              bad_byte_seen;
        logic [CNT_W-1:0]  length_so_far;
        logic [CNT_W-1:0]  digit_count;
        logic [ODD_W-1:0]  odd_digit_sum;
        logic [EVEN_W-1:0] even_digit_sum;
        logic [7:0]        held_second_letter;
        logic [3:0]        held_first_digit;
        logic [3:0]        held_second_digit;
    } t_snap;

    typedef struct packed {
        logic                serial_ok;
        logic [LEN_W-1:0]    text_length;
        logic                check_ok;
        logic [DIGIT_W-1:0]  chk_digit;
        logic [REGION_W-1:0] region_code;
        logic                region_found;
        logic [SUB_W-1:0]    submodel_code;
    } t_result;

    function automatic logic [REGION_W-1:0] region_of(input logic [7:0] ch);
        logic [REGION_W-1:0] code;
        case (ch)
            "J":     code = REG_JP;
            "W":     code = REG_AMER;
            "E":     code = REG_EU;
            "C":     code = REG_CN;
            "K":     code = REG_KR;
            "T":     code = REG_TW;
            "U":     code = REG_UK;
            "S":     code = REG_MIDEAST;
            "A":     code = REG_AU;
            "B":     code = REG_BR;
            default: code = REG_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

>>> sv/scd_scan.sv
// ----------------------------------------------------------------------------
// scd_scan - serial byte scanner
// Running counts and sums per record; hands totals to a snapshot register.
// ----------------------------------------------------------------------------
module scd_scan
    import scd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_adv,      // result stage takes the snapshot this cycle
    output logic       o_snap_vld,
    output t_snap      o_snap
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_stopped, n_stopped;
    logic [1:0]       r_lc, n_lc;
    t_snap            r_acc, n_acc;
    logic             r_snap_vld;
    t_snap            r_snap;
    logic             accept, active, is_digit, is_bad;
    logic [CNT_W-1:0] dc_inc;
    logic [3:0]       dval;

    assign o_ready = !r_snap_vld || i_adv;
    assign accept  = i_valid && o_ready;

    always_comb begin
        active   = !r_stopped && (r_pos < POS_W'(FIELD_BYTES));
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        is_bad   = (i_byte < CH_SPACE) || (i_byte > CH_TILDE);
        dval     = i_byte[3:0];
        dc_inc   = r_acc.digit_count + CNT_W'(1);
        n_pos     = r_pos;
        n_stopped = r_stopped;
        n_lc      = r_lc;
        n_acc     = r_acc;
        if (active) begin
            n_pos = r_pos + POS_W'(1);
            if (i_byte == CH_NUL) begin
                n_stopped = 1'b1;
            end else if (is_bad) begin
                n_stopped = 1'b1;
                n_acc.bad_byte_seen = 1'b1;
            end else begin
                n_acc.length_so_far = r_acc.length_so_far + CNT_W'(1);
                if (is_digit) begin
                    n_acc.digit_count = dc_inc;
                    if (dc_inc[0]) begin
                        n_acc.odd_digit_sum = r_acc.odd_digit_sum + ODD_W'(dval);
                    end else begin
                        n_acc.even_digit_sum = r_acc.even_digit_sum + EVEN_W'(dval);
                    end
                    if (dc_inc == CNT_W'(1)) begin
                        n_acc.held_first_digit = dval;
                    end else if (dc_inc == CNT_W'(2)) begin
                        n_acc.held_second_digit = dval;
                    end
                end else if (r_lc < 2'd2) begin
                    n_lc = r_lc + 2'd1;
                    if (r_lc == 2'd1) begin
                        n_acc.held_second_letter = i_byte;
                    end
                end
            end
        end
    end

    // Record state; cleared on the record's last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_stopped <= 1'b0;
            r_lc      <= '0;
            r_acc     <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_pos     <= '0;
                r_stopped <= 1'b0;
                r_lc      <= '0;
                r_acc     <= '0;
            end else begin
                r_pos     <= n_pos;
                r_stopped <= n_stopped;
                r_lc      <= n_lc;
                r_acc     <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (accept && i_last) begin
            r_snap_vld <= 1'b1;
        end else if (i_adv) begin
            r_snap_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_snap <= n_acc;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

endmodule

>>> sv/scd_result.sv
// ----------------------------------------------------------------------------
// scd_result - record result stage
// Check digit, region and sub-model decode into the output register.
// ----------------------------------------------------------------------------
module scd_result
    import scd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_snap_vld,
    input  t_snap   i_snap,
    input  t_cfg    i_cfg,
    output logic    o_adv,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic              r_out_vld;
    t_result           r_res, n_res;
    logic [WSUM_W-1:0] wsum;
    logic [PROD_W-1:0] prod;
    logic [WSUM_W-1:0] quot;
    logic [WSUM_W-1:0] rem;
    logic [SUB_W-1:0]  sub;

    assign o_adv = !r_out_vld || i_ready;

    always_comb begin
        wsum = WSUM_W'(i_snap.odd_digit_sum) + WSUM_W'(i_snap.even_digit_sum)
             + WSUM_W'({i_snap.even_digit_sum, 1'b0});
        prod = PROD_W'(wsum) * PROD_W'(DIV10_MUL);
        quot = WSUM_W'(prod >> DIV10_SHIFT);
        rem  = wsum - WSUM_W'(quot * WSUM_W'(10));

        // Sub-model from the first two digits and the console settings
        if (i_snap.digit_count < CNT_W'(2)) begin
            sub = SUB_UNKNOWN;
        end else if (i_cfg.devkit_mode) begin
            sub = SUB_PANDA;
            if (i_snap.held_first_digit == 4'd9 && i_snap.held_second_digit == 4'd0
                && i_cfg.console_model == MODEL_OLD) begin
                sub = SUB_PARTNER;
            end else if (i_snap.held_first_digit == 4'd9
                         && i_snap.held_second_digit == 4'd1) begin
                case (i_cfg.console_model)
                    MODEL_OLD:    sub = SUB_CTR_BOX;
                    MODEL_OLD_XL: sub = SUB_SPR_BOX;
                    MODEL_NEW:    sub = SUB_SNK_BOX;
                    default:      sub = SUB_PANDA;
                endcase
            end
        end else if (i_snap.held_first_digit == 4'd0 && i_snap.held_second_digit == 4'd1
                     && !i_cfg.old_family) begin
            sub = SUB_PRESS;
        end else begin
            sub = SUB_RETAIL;
        end

        n_res = '0;
        if (!i_snap.bad_byte_seen) begin
            n_res.serial_ok   = 1'b1;
            n_res.text_length = (i_snap.length_so_far > CNT_W'(15)) ? LEN_W'(15)
                                                                   : LEN_W'(i_snap.length_so_far);
            if (i_snap.digit_count == CNT_W'(8)
                && i_snap.length_so_far < CNT_W'(FIELD_BYTES)) begin
                n_res.check_ok  = 1'b1;
                n_res.chk_digit = (rem == '0) ? '0 : DIGIT_W'(WSUM_W'(10) - rem);
            end
            if (i_snap.held_second_letter != CH_NUL) begin
                n_res.region_found = 1'b1;
                n_res.region_code  = region_of(i_snap.held_second_letter);
            end
            n_res.submodel_code = sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= i_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_snap_vld) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_res;

    // A rejected serial carries no other information
    a_bad_serial_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_res.serial_ok |-> r_res.text_length == '0 && !r_res.check_ok
            && r_res.submodel_code == SUB_UNKNOWN)
        else $error("invalid serial with non-zero fields");

    a_check_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_res.check_ok ? (r_res.chk_digit < DIGIT_W'(10))
                                      : (r_res.chk_digit == '0)))
        else $error("check digit out of range");

    a_region_needs_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_res.region_found |-> r_res.region_code == REG_UNKNOWN)
        else $error("region code without second letter");

    a_result_follows_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && i_snap_vld |=> r_out_vld)
        else $error("snapshot taken but no result");

endmodule

>>> sv/serial_check_digit_decoder.sv
// ----------------------------------------------------------------------------
// serial_check_digit_decoder - serial field scanner and check digit decoder
// Scans a fixed serial field byte by byte and reports one result per record.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of the serial field arrive on the s_axis channel, one per
//   transaction, in order; s_axis_tlast marks the last byte of a record.
//   Each record gives exactly one result transaction on m_axis: validity,
//   text length, 3/1 weighted mod-10 check digit, region and sub-model code.
//   Bytes after a NUL, after a bad byte or beyond the field size are taken
//   but ignored.
//   Throughput: one byte per cycle, sustained, while s_axis_tready is high.
//   The last byte loads the snapshot; its decode goes to the output register.
//   When m_axis_tready is low the result holds; the snapshot register still
//   absorbs one more record end, and s_axis_tready only drops once both are
//   full. Bytes of an open record keep flowing while either is empty.
//   Configuration writes (devkit mode, console model, old family) go over the
//   cfg channel, always ready; the user must make them only while the block
//   is idle, which the block itself does not enforce. Reset (synchronous,
//   active low) clears all record state, drops all valids and loads
//   devkit_mode 0, console_model 255, old_family 0.
// ----------------------------------------------------------------------------
module serial_check_digit_decoder
    import scd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Byte stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] serial_byte
    input  logic                   s_axis_tlast,   // record_end
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] serial_ok, [4:1] text_length, [5] check_ok, [9:6] chk_digit,
    // [13:10] region_code, [14] region_found, [17:15] submodel_code, rest 0
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    t_cfg    r_cfg;
    t_snap   snap;
    t_result res;
    logic    snap_vld;
    logic    adv;
    logic    cfg_wr;

    // Register file: three settings, unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.devkit_mode   <= 1'b0;
            r_cfg.console_model <= MODEL_UNKNOWN;
            r_cfg.old_family    <= 1'b0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_DEVKIT:     r_cfg.devkit_mode   <= i_cfg_data[0];
                CFG_MODEL:      r_cfg.console_model <= i_cfg_data;
                CFG_OLD_FAMILY: r_cfg.old_family    <= i_cfg_data[0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    // Per-byte scan with record snapshot
    scd_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_adv      (adv),
        .o_snap_vld (snap_vld),
        .o_snap     (snap)
    );

    // Per-record decode into the output register
    scd_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap_vld (snap_vld),
        .i_snap     (snap),
        .i_cfg      (r_cfg),
        .o_adv      (adv),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (res)
    );

    assign m_axis_tdata = {6'd0, res.submodel_code, res.region_found, res.region_code,
                           res.chk_digit, res.check_ok, res.text_length, res.serial_ok};

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - serial check digit decoder testbench
// Streams serial field records into the decoder under several register
// settings, predicts each record's result in a local model of the scanner
// and compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import scd_pkg::*;
();

    // Index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // Result path is two registers deep; a few spare cycles before idling
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;

    // Second-letter decode table
    localparam logic [7:0] REGION_LETTERS [10] =
        '{"J", "W", "E", "C", "K", "T", "U", "S", "A", "B"};
    localparam logic [REGION_W-1:0] REGION_CODES [10] =
        '{REG_JP, REG_AMER, REG_EU, REG_CN, REG_KR,
          REG_TW, REG_UK, REG_MIDEAST, REG_AU, REG_BR};

    typedef logic [7:0] t_serial_bytes [$];

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;  // [7:0] serial_byte
    logic                   s_axis_tlast  = 1'b0;   // record_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] serial_ok, [4:1] text_length, [5] check_ok, [9:6] chk_digit,
    // [13:10] region_code, [14] region_found, [17:15] submodel_code
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index   = 2'd0;
    logic [7:0]             i_cfg_data    = 8'h00;

    // Register mirror, reset values
    logic       cfg_devkit = 1'b0;
    logic [7:0] cfg_model  = MODEL_UNKNOWN;
    logic       cfg_old    = 1'b0;

    // Running state of the record being scanned
    logic [POS_W-1:0]  rec_pos           = '0;
    logic              rec_stopped       = 1'b0;
    logic              rec_bad           = 1'b0;
    logic [CNT_W-1:0]  rec_digits        = '0;
    logic [CNT_W-1:0]  rec_len           = '0;
    logic [ODD_W-1:0]  rec_odd_sum       = '0;
    logic [EVEN_W-1:0] rec_even_sum      = '0;
    logic [1:0]        rec_letters       = '0;
    logic [7:0]        rec_second_letter = '0;
    logic [3:0]        rec_first_digit   = '0;
    logic [3:0]        rec_second_digit  = '0;

    t_result pending_results [$];
    int      error_count = 0;

    // Traffic shaping
    bit tx_gaps        = 1'b1;
    int tx_burst_left  = 0;
    bit rx_stalls      = 1'b1;
    int rx_hold_cycles = 0;
    int rx_run_left    = 0;

    serial_check_digit_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Scanner model: one call per accepted byte transaction. On the record's
    // last byte the expected result is queued and the record state cleared.
    // ------------------------------------------------------------------------
    task automatic scan_serial_byte(input logic [7:0] ch, input logic last);
        t_result    res;
        logic [3:0] digit;
        int         wsum;
        // Bytes after a stop or past the field are dropped
        if (!rec_stopped && rec_pos < FIELD_BYTES) begin
            rec_pos++;
            if (ch == CH_NUL) begin
                rec_stopped = 1'b1;
            end else if (ch < CH_SPACE || ch > CH_TILDE) begin
                rec_bad     = 1'b1;
                rec_stopped = 1'b1;
            end else begin
                rec_len++;
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    digit = 4'(ch - CH_ZERO);
                    rec_digits++;
                    // first digit counts as odd position
                    if (rec_digits[0])
                        rec_odd_sum += digit;
                    else
                        rec_even_sum += digit;
                    if (rec_digits == 1)
                        rec_first_digit = digit;
                    else if (rec_digits == 2)
                        rec_second_digit = digit;
                end else if (rec_letters < 2) begin
                    rec_letters++;
                    if (rec_letters == 2)
                        rec_second_letter = ch;
                end
            end
        end
        if (!last)
            return;

        // Invalid serial leaves every field at zero
        res = '0;
        if (!rec_bad) begin
            res.serial_ok   = 1'b1;
            res.text_length = (int'(rec_len) > 15) ? '1 : LEN_W'(rec_len);
            if (rec_digits == 8 && rec_len < FIELD_BYTES) begin
                res.check_ok  = 1'b1;
                wsum          = int'(rec_odd_sum) + 3 * int'(rec_even_sum);
                res.chk_digit = DIGIT_W'((10 - wsum % 10) % 10);
            end
            if (rec_second_letter != CH_NUL) begin
                res.region_found = 1'b1;
                res.region_code  = REG_UNKNOWN;
                for (int i = 0; i < 10; i++)
                    if (REGION_LETTERS[i] == rec_second_letter)
                        res.region_code = REGION_CODES[i];
            end
            if (rec_digits < 2)
                res.submodel_code = SUB_UNKNOWN;
            else if (cfg_devkit) begin
                if (rec_first_digit == 9 && rec_second_digit == 0 && cfg_model == MODEL_OLD)
                    res.submodel_code = SUB_PARTNER;
                else if (rec_first_digit == 9 && rec_second_digit == 1 && cfg_model == MODEL_OLD)
                    res.submodel_code = SUB_CTR_BOX;
                else if (rec_first_digit == 9 && rec_second_digit == 1
                         && cfg_model == MODEL_OLD_XL)
                    res.submodel_code = SUB_SPR_BOX;
                else if (rec_first_digit == 9 && rec_second_digit == 1 && cfg_model == MODEL_NEW)
                    res.submodel_code = SUB_SNK_BOX;
                else
                    res.submodel_code = SUB_PANDA;
            end else if (rec_first_digit == 0 && rec_second_digit == 1 && !cfg_old)
                res.submodel_code = SUB_PRESS;
            else
                res.submodel_code = SUB_RETAIL;
        end
        pending_results.push_back(res);

        rec_pos           = '0;
        rec_stopped       = 1'b0;
        rec_bad           = 1'b0;
        rec_digits        = '0;
        rec_len           = '0;
        rec_odd_sum       = '0;
        rec_even_sum      = '0;
        rec_letters       = '0;
        rec_second_letter = '0;
        rec_first_digit   = '0;
        rec_second_digit  = '0;
    endtask

    task automatic compare_field(input string field, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            error_count++;
        end
    endtask

    // Both streams are sampled at the rising edge; inputs move on the falling
    // edge, so nothing here races the drivers.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            scan_serial_byte(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no record outstanding: %h", m_axis_tdata);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                compare_field("serial_ok",     exp_res.serial_ok,     m_axis_tdata[0]);
                compare_field("text_length",   exp_res.text_length,   m_axis_tdata[4:1]);
                compare_field("check_ok",      exp_res.check_ok,      m_axis_tdata[5]);
                compare_field("chk_digit",     exp_res.chk_digit,     m_axis_tdata[9:6]);
                compare_field("region_code",   exp_res.region_code,   m_axis_tdata[13:10]);
                compare_field("region_found",  exp_res.region_found,  m_axis_tdata[14]);
                compare_field("submodel_code", exp_res.submodel_code, m_axis_tdata[17:15]);
                compare_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:18]);
            end
        end
    end

    // Result sink: always ready when stalls are off, else alternating ready and
    // stall runs of random length, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            rx_hold_cycles--;
        end else if (!rx_stalls) begin
            m_axis_tready = 1'b1;
        end else if (rx_run_left > 0) begin
            rx_run_left--;
        end else begin
            m_axis_tready = !m_axis_tready;
            rx_run_left   = m_axis_tready ? $urandom_range(0, 10) : $urandom_range(0, 5);
        end
    end

    // One byte transaction, with gaps between random-length bursts if tx_gaps;
    // tvalid stays high on return, so the caller either sends again or goes idle.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        if (tx_gaps && tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 20);
            gap           = $urandom_range(1, 6);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_record(input t_serial_bytes rec);
        foreach (rec[i])
            send_byte(rec[i], i == rec.size() - 1);
    endtask

    // Sender goes quiet until every outstanding result is in
    task automatic wait_for_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_DEVKIT:     cfg_devkit = value[0];
            CFG_MODEL:      cfg_model  = value;
            CFG_OLD_FAMILY: cfg_old    = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly region letters, else any printable non-digit
    function automatic logic [7:0] random_letter();
        logic [7:0] ch;
        if ($urandom_range(0, 9) < 7)
            return REGION_LETTERS[$urandom_range(0, 9)];
        do ch = 8'($urandom_range(CH_SPACE, CH_TILDE));
        while (ch >= CH_ZERO && ch <= CH_NINE);
        return ch;
    endfunction

    // Mostly serial-shaped records (letters, eight digits, NUL padding),
    // the rest printable mixes, raw noise, bad bytes and overlong fields.
    task automatic send_random_record(input bit short_rec);
        t_serial_bytes rec;
        int            kind;
        int            n;
        int            pair;
        int            sel;
        logic [7:0]    d1;
        logic [7:0]    d2;
        rec  = {};
        kind = short_rec ? 6 : $urandom_range(0, 9);
        if (kind <= 4 || kind == 8) begin
            repeat ($urandom_range(0, 3)) rec.push_back(random_letter());
            // lead digit pairs that steer the sub-model decode
            pair = $urandom_range(0, 3);
            d1   = (pair == 3) ? 8'($urandom_range(0, 9)) : (pair == 2) ? 8'd0 : 8'd9;
            d2   = (pair == 3) ? 8'($urandom_range(0, 9)) : (pair == 0) ? 8'd0 : 8'd1;
            n    = ($urandom_range(0, 3) != 0) ? 8 : $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
                rec.push_back(CH_ZERO + ((i == 0) ? d1 : (i == 1) ? d2
                                         : 8'($urandom_range(0, 9))));
            repeat ($urandom_range(0, 2)) rec.push_back(random_letter());
            if (rec.size() < FIELD_BYTES && $urandom_range(0, 1)) begin
                rec.push_back(CH_NUL);
                while (rec.size() < FIELD_BYTES && $urandom_range(0, 3) != 0)
                    rec.push_back(8'($urandom_range(0, 255)));
            end
            if (kind == 8 && rec.size() > 0)
                rec[$urandom_range(0, rec.size() - 1)] = $urandom_range(0, 1)
                    ? 8'($urandom_range(1, CH_SPACE - 1))
                    : 8'($urandom_range(CH_TILDE + 1, 255));
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 18)) rec.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = (kind == 9) ? $urandom_range(FIELD_BYTES, FIELD_BYTES + 3)
              : short_rec   ? $urandom_range(1, 4)
              :               $urandom_range(1, 14);
            repeat (n) begin
                sel = $urandom_range(0, 7);
                if (sel < 4)
                    rec.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                else if (sel < 7)
                    rec.push_back(random_letter());
                else
                    rec.push_back(CH_NUL);
            end
        end
        if (rec.size() == 0)
            rec.push_back(CH_NUL);
        send_record(rec);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked records under reset register values
    task automatic test_directed_records();
        t_serial_bytes rec;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        // empty text
        rec = {CH_NUL};
        send_record(rec);
        // non-printable at once: invalid serial
        rec = {8'hFF};
        send_record(rec);
        // printable extremes as letters, then a control byte kills the serial
        rec = {CH_SPACE, CH_TILDE, 8'h1F, "A"};
        send_record(rec);
        // second letter J, retail digits, junk after the NUL is ignored
        rec = {"X", "J", "9", "1", CH_NUL, 8'hFF};
        send_record(rec);
        // full field of ten digits and five letters, one byte past the field
        rec = {};
        for (int i = 0; i < FIELD_BYTES; i++)
            rec.push_back((i < 10) ? CH_ZERO + 8'(i) : "A" + 8'(i - 10));
        rec.push_back(8'h7F);
        send_record(rec);
    endtask

    // Register settings walk, model extremes and unknown models included;
    // idling pattern varies per setting and one setting runs flat out.
    task automatic test_register_settings();
        logic       set_devkit [8];
        logic [7:0] set_model  [8];
        logic       set_old    [8];
        logic [7:0] model;
        set_devkit = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        set_model  = '{MODEL_UNKNOWN, MODEL_OLD, MODEL_OLD_XL, MODEL_NEW,
                       MODEL_UNKNOWN, MODEL_OLD, MODEL_NEW, MODEL_UNKNOWN};
        set_old    = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        for (int p = 0; p < 8; p++) begin
            wait_for_results();
            // last setting: some model index nobody knows
            model = (p == 7) ? 8'($urandom_range(MODEL_NEW + 1, MODEL_UNKNOWN - 1))
                             : set_model[p];
            write_reg(CFG_DEVKIT, {7'($urandom), set_devkit[p]});
            write_reg(CFG_MODEL, model);
            write_reg(CFG_OLD_FAMILY, {7'($urandom), set_old[p]});
            tx_gaps   = (p % 3 != 2);
            rx_stalls = (p % 4 != 2);
            repeat (14) send_random_record(1'b0);
        end
    endtask

    // A write to an index with no register must leave all settings alone
    task automatic test_unused_register();
        wait_for_results();
        write_reg(CFG_DEVKIT, 8'h01);
        write_reg(CFG_MODEL, MODEL_OLD);
        write_reg(CFG_UNUSED, 8'hFF);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (6) send_random_record(1'b0);
    endtask

    // Sink holds off for a long stretch while short records keep coming, so
    // both result registers fill and the byte stream stalls.
    task automatic test_backpressure();
        wait_for_results();
        tx_gaps        = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (30) send_random_record(1'b1);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (10) send_random_record(1'b0);
    endtask

    initial begin
        // reset held low from time zero, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_records();
        test_register_settings();
        test_unused_register();
        test_backpressure();

        wait_for_results();
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
